/* rtl/core/iir_lowpass_with_output_clamp_core_defines.svh */
// ----------------------------------------------------------------------------
// iir low-pass core assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef IIR_LOWPASS_WITH_OUTPUT_CLAMP_CORE_DEFINES_SVH
`define IIR_LOWPASS_WITH_OUTPUT_CLAMP_CORE_DEFINES_SVH

// property checked outside reset
`define IIRLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iirlp assertion failed");

// property checked on every edge, reset included
`define IIRLP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("iirlp assertion failed");

`endif

/* rtl/core/iirlp_pkg.sv */
// ----------------------------------------------------------------------------
// iirlp_pkg
// types and constants of the iir low-pass core
// ----------------------------------------------------------------------------
package iirlp_pkg;

  localparam int X_W      = 16;
  localparam int COEF_W   = 24;
  localparam int Y_W      = 24;
  localparam int LIM_W    = 15;
  localparam int PROD_W   = 48;
  localparam int ACC_W    = 51;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;
  localparam int HIST_D   = 3;
  localparam int FRAC_SHIFT = 20;

  typedef logic signed [X_W-1:0]    sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [Y_W-1:0]    yval_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [LIM_W-1:0]         limit_t;
  typedef coef_t [3:0]              num_bank_t;
  typedef coef_t [3:1]              den_bank_t;

  localparam acc_t ACC_ROUND_BIAS = acc_t'(64'sd524288);
  localparam acc_t ACC_Y_MAX      = acc_t'(64'sd8388607);
  localparam acc_t ACC_Y_MIN      = acc_t'(-64'sd8388608);
  localparam limit_t LIMIT_RESET  = limit_t'(15'h7fff);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM0  = 4'd0,
    CFG_NUM1  = 4'd1,
    CFG_NUM2  = 4'd2,
    CFG_NUM3  = 4'd3,
    CFG_DEN1  = 4'd4,
    CFG_DEN2  = 4'd5,
    CFG_DEN3  = 4'd6,
    CFG_LIMIT = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic sub;
  } mac_ctl_t;

endpackage

/* rtl/core/iirlp_in_if.sv */
// ----------------------------------------------------------------------------
// iirlp_in_if
// sample channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface iirlp_in_if import iirlp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* rtl/core/iirlp_out_if.sv */
// ----------------------------------------------------------------------------
// iirlp_out_if
// filtered result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface iirlp_out_if import iirlp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

/* rtl/core/iir_lowpass_with_output_clamp_core.sv */
// ----------------------------------------------------------------------------
// iir_lowpass_with_output_clamp_core
// direct-form-i iir low-pass, order up to three, with symmetric output clamp
// ----------------------------------------------------------------------------
// One multiplier and accumulator is stepped through the taps: current input,
// then for each order k the k-th past input and the k-th past output. The
// product register is then drained, the sum is rounded and saturated to 24
// bits (this updates the histories) and clamped into the output register.
// in_ch.ready is high only while the core is idle, so the next sample is
// taken only after the last has gone through these steps. A finished result
// waits in the output register while the next sample is taken in; the core
// holds in its last cycle only if the previous result is still not taken.
// Coefficients are to be written through cfg_* while idle; the block itself
// does not enforce it. Indexes above 7 are ignored.
// ----------------------------------------------------------------------------
module iir_lowpass_with_output_clamp_core import iirlp_pkg::*; #(
  parameter int FILTER_ORDER = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  iirlp_in_if.sink              in_ch,
  iirlp_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  num_bank_t num_coef;
  den_bank_t den_coef;
  limit_t    output_limit;
  mac_ctl_t  mac_ctl;
  coef_t     mac_opa;
  coef_t     mac_opc;
  acc_t      mac_acc;

  iirlp_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .num_coef     (num_coef),
    .den_coef     (den_coef),
    .output_limit (output_limit)
  );

  iirlp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .opa   (mac_opa),
    .opc   (mac_opc),
    .acc   (mac_acc)
  );

  iirlp_ctrl #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .sample_in    (in_ch.sample_in),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .filtered_out (out_ch.filtered_out),
    .num_coef     (num_coef),
    .den_coef     (den_coef),
    .output_limit (output_limit),
    .mac_ctl      (mac_ctl),
    .mac_opa      (mac_opa),
    .mac_opc      (mac_opc),
    .mac_acc      (mac_acc)
  );

endmodule

/* rtl/core/iirlp_cfg.sv */
// ----------------------------------------------------------------------------
// iirlp_cfg
// coefficient and output limit register file
// ----------------------------------------------------------------------------
module iirlp_cfg import iirlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output num_bank_t             num_coef,
  output den_bank_t             den_coef,
  output limit_t                output_limit
);

  num_bank_t num_r;
  den_bank_t den_r;
  limit_t    lim_r;
  logic [1:0] den_sel;

  assign den_sel = 2'(cfg_idx - 4'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
      den_r <= '0;
      lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NUM0, CFG_NUM1, CFG_NUM2, CFG_NUM3: begin
          num_r[cfg_idx[1:0]] <= coef_t'(cfg_wdata);
        end
        CFG_DEN1, CFG_DEN2, CFG_DEN3: begin
          den_r[den_sel] <= coef_t'(cfg_wdata);
        end
        CFG_LIMIT: begin
          lim_r <= cfg_wdata[LIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign num_coef     = num_r;
  assign den_coef     = den_r;
  assign output_limit = lim_r;

endmodule

/* rtl/core/iirlp_mac.sv */
// ----------------------------------------------------------------------------
// iirlp_mac
// shared multiply-accumulate unit, registered product then add/subtract
// ----------------------------------------------------------------------------
module iirlp_mac import iirlp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  coef_t    opa,
  input  coef_t    opc,
  output acc_t     acc
);

  prod_t prod_w;
  prod_t prod_r;
  logic  psub_r;
  logic  pvld_r;
  acc_t  acc_r;

  assign prod_w = opa * opc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= ctl.en && !ctl.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_w;
      psub_r <= ctl.sub;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pvld_r) begin
      if (psub_r) begin
        acc_r <= acc_r - acc_t'(prod_r);
      end else begin
        acc_r <= acc_r + acc_t'(prod_r);
      end
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/core/iirlp_ctrl.sv */
// ----------------------------------------------------------------------------
// iirlp_ctrl
// tap sequencer, histories, rounding, saturation and output clamp
// ----------------------------------------------------------------------------
module iirlp_ctrl import iirlp_pkg::*; #(
  parameter int FILTER_ORDER = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sample_t   sample_in,
  output logic      out_valid,
  input  logic      out_ready,
  output sample_t   filtered_out,
  input  num_bank_t num_coef,
  input  den_bank_t den_coef,
  input  limit_t    output_limit,
  output mac_ctl_t  mac_ctl,
  output coef_t     mac_opa,
  output coef_t     mac_opc,
  input  acc_t      mac_acc
);

  localparam int LAST = 2 * FILTER_ORDER;
  localparam int SW   = $clog2(LAST + 1);

  state_t      state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  sample_t     x_r;
  sample_t     xh_r [HIST_D];
  yval_t       yh_r [HIST_D];
  yval_t       y_r;
  logic        out_valid_r;
  sample_t     out_data_r;

  logic [SW:0] tap_w;
  logic [1:0]  tap;
  logic [1:0]  hidx;
  logic        is_den;
  acc_t        rsum;
  acc_t        rshift;
  yval_t       y_sat;
  yval_t       lim_pos;
  yval_t       lim_neg;
  sample_t     clamped;
  logic        in_acc;
  logic        emit_go;

  assign tap_w  = ((SW+1)'(step_r) + (SW+1)'(1)) >> 1;
  assign tap    = 2'(tap_w);
  assign hidx   = 2'(tap - 2'd1);
  assign is_den = (step_r != '0) && !step_r[0];

  always_comb begin
    if (step_r == '0) begin
      mac_opa = coef_t'(x_r);
      mac_opc = num_coef[0];
    end else if (is_den) begin
      mac_opa = yh_r[hidx];
      mac_opc = den_coef[tap];
    end else begin
      mac_opa = coef_t'(xh_r[hidx]);
      mac_opc = num_coef[tap];
    end
  end

  assign rsum   = mac_acc + ACC_ROUND_BIAS;
  assign rshift = rsum >>> FRAC_SHIFT;

  always_comb begin
    if (rshift > ACC_Y_MAX) begin
      y_sat = yval_t'(ACC_Y_MAX);
    end else if (rshift < ACC_Y_MIN) begin
      y_sat = yval_t'(ACC_Y_MIN);
    end else begin
      y_sat = yval_t'(rshift);
    end
  end

  assign lim_pos = yval_t'({1'b0, output_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (y_r > lim_pos) begin
      clamped = sample_t'(lim_pos);
    end else if (y_r < lim_neg) begin
      clamped = sample_t'(lim_neg);
    end else begin
      clamped = sample_t'(y_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    mac_ctl.clr = 1'b0;
    mac_ctl.en  = 1'b0;
    mac_ctl.sub = is_den;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mac_ctl.clr = 1'b1;
          step_nxt    = '0;
          state_nxt   = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctl.en = 1'b1;
        if (step_r == SW'(LAST)) begin
          state_nxt = ST_FLUSH;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_D; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ROUND) begin
        xh_r[0] <= x_r;
        yh_r[0] <= y_sat;
        for (int i = 1; i < HIST_D; i++) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= sample_in;
    end
    if (state_r == ST_ROUND) begin
      y_r <= y_sat;
    end
    if (emit_go) begin
      out_data_r <= clamped;
    end
  end

  assign out_valid    = out_valid_r;
  assign filtered_out = out_data_r;

endmodule

/* rtl/core/iirlp_chk.sv */
// ----------------------------------------------------------------------------
// iirlp_chk
// port-level checks of the iir low-pass core, bound to the top level
// ----------------------------------------------------------------------------
`include "iir_lowpass_with_output_clamp_core_defines.svh"

module iirlp_chk import iirlp_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t filtered_out
);

  // no result right after reset
  `IIRLP_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid)

  // one transaction at a time: busy after an accepted sample
  `IIRLP_ASSERT(a_busy_after_in, (in_valid && in_ready) |=> !in_ready)

  // a new result only follows a cycle of work
  `IIRLP_ASSERT(a_out_after_work, $rose(out_valid) |-> !$past(in_ready))

  // stalled result holds
  `IIRLP_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(filtered_out)))

endmodule

bind iir_lowpass_with_output_clamp_core iirlp_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .filtered_out (out_ch.filtered_out)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the iir low-pass core with output clamp
// ----------------------------------------------------------------------------
// Samples go in through a queue-fed driver. Each accepted sample runs through
// a fixed-point filter predictor, a direct-form-i sum with rounding, 24-bit
// saturation and a symmetric clamp. The monitor compares every filtered
// transaction with the oldest prediction. Coefficients and the clamp limit are
// rewritten between phases while the core is idle. The phases mix source gaps,
// sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iirlp_pkg::*;

  localparam int FILTER_ORDER = 3;
  localparam int DRAIN_CYCLES = 2 * FILTER_ORDER + 15;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int STABLE_COEF_SPAN = 1 << 18;
  localparam longint ROUND_HALF = 64'sd1 << (FRAC_SHIFT - 1);
  localparam longint Y_SAT_MAX = 64'sd8388607;
  localparam longint Y_SAT_MIN = -64'sd8388608;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = sample_t'(16'h8000);
  localparam sample_t SAMPLE_ZERO = 16'sh0000;
  localparam sample_t SAMPLE_ONE = 16'sh0001;
  localparam sample_t SAMPLE_NEG_ONE = sample_t'(16'hffff);
  localparam coef_t COEF_MAX = 24'sh7fffff;
  localparam coef_t COEF_MIN = coef_t'(24'h800000);
  localparam coef_t COEF_UNITY = coef_t'(1 << FRAC_SHIFT);
  localparam limit_t LIM_MAX = '1;
  localparam limit_t LIM_ONE = limit_t'(1);
  localparam limit_t LIM_ZERO = '0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  iirlp_in_if in_ch ();
  iirlp_out_if out_ch ();

  iir_lowpass_with_output_clamp_core #(
    .FILTER_ORDER(FILTER_ORDER)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter state and register copy
  coef_t num_coef_q [0:3];
  coef_t den_coef_q [1:3];
  limit_t clamp_limit;
  sample_t x_hist [0:2];
  yval_t y_hist [0:2];

  sample_t sample_queue [$];
  sample_t filtered_expected [$];
  sample_t directed_items [$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  bit hold_trigger = 1'b0;
  bit hold_seen = 1'b0;

  function automatic sample_t filter_step(sample_t x);
    longint acc;
    longint y;
    longint lim;
    acc = longint'(num_coef_q[0]) * longint'(x);
    for (int k = 1; k <= FILTER_ORDER; k++) begin
      acc += longint'(num_coef_q[k]) * longint'(x_hist[k-1]);
      acc -= longint'(den_coef_q[k]) * longint'(y_hist[k-1]);
    end
    y = (acc + ROUND_HALF) >>> FRAC_SHIFT;
    if (y > Y_SAT_MAX) y = Y_SAT_MAX;
    if (y < Y_SAT_MIN) y = Y_SAT_MIN;
    for (int k = 2; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = yval_t'(y);
    lim = longint'(clamp_limit);
    if (y > lim) y = lim;
    if (y < -lim) y = -lim;
    return sample_t'(y);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_NUM0: num_coef_q[0] = coef_t'(data);
      CFG_NUM1: num_coef_q[1] = coef_t'(data);
      CFG_NUM2: num_coef_q[2] = coef_t'(data);
      CFG_NUM3: num_coef_q[3] = coef_t'(data);
      CFG_DEN1: den_coef_q[1] = coef_t'(data);
      CFG_DEN2: den_coef_q[2] = coef_t'(data);
      CFG_DEN3: den_coef_q[3] = coef_t'(data);
      CFG_LIMIT: clamp_limit = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_config();
    int unsigned style;
    int unsigned lim_pick;
    int v;
    style = $urandom_range(2);
    for (int k = CFG_NUM0; k <= CFG_DEN3; k++) begin
      if (style == 0) begin
        write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
      end else begin
        // small taps keep the feedback stable
        v = int'($urandom_range(2 * STABLE_COEF_SPAN)) - STABLE_COEF_SPAN;
        write_reg(CFG_IDX_W'(k), v[CFG_DATA_W-1:0]);
      end
    end
    lim_pick = $urandom_range(7);
    if (lim_pick == 0) write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_ZERO));
    else if (lim_pick <= 2) write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_MAX));
    else write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(32767)));
    if ($urandom_range(1) == 1)
      write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_HI, CFG_IDX_UNUSED_LO)),
                CFG_DATA_W'($urandom));
    end_writes();
  endtask

  task automatic run_items(input sample_t items[$], input int unsigned src_idle,
                           input int unsigned snk_stall, input bit long_hold);
    @(negedge clk);
    src_idle_pct = src_idle;
    snk_stall_pct = snk_stall;
    foreach (items[i]) sample_queue.push_back(items[i]);
    if (long_hold) hold_trigger = ~hold_trigger;
    wait (sample_queue.size() == 0 && !in_ch.valid && filtered_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int unsigned n, input int unsigned src_idle,
                                  input int unsigned snk_stall, input bit long_hold);
    sample_t items [$];
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(15);
      if (pick == 0) items.push_back(SAMPLE_MAX);
      else if (pick == 1) items.push_back(SAMPLE_MIN);
      else if (pick <= 5) items.push_back(sample_t'($urandom_range(511)) - sample_t'(256));
      else items.push_back(sample_t'($urandom));
    end
    run_items(items, src_idle, snk_stall, long_hold);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample_in <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) filtered_expected.push_back(filter_step(in_ch.sample_in));
      if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= sample_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long sink hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
    end
  end

  // filtered transaction monitor
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (filtered_expected.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected filtered_out %0d", $realtime, out_ch.filtered_out);
          fail_count++;
        end else begin
          want = filtered_expected.pop_front();
          if (out_ch.filtered_out !== want) begin
            if (fail_count < 10)
              $display("%0t: filtered_out mismatch, expected %0d, got %0d",
                       $realtime, want, out_ch.filtered_out);
            fail_count++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned src_modes [4];
    int unsigned snk_modes [4];
    src_modes = '{0, 66, 0, 24};
    snk_modes = '{0, 0, 66, 24};
    for (int k = 0; k < 4; k++) num_coef_q[k] = '0;
    for (int k = 1; k < 4; k++) den_coef_q[k] = '0;
    for (int k = 0; k < 3; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
    clamp_limit = LIM_MAX;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients give zero output
    directed_items = {SAMPLE_MAX, SAMPLE_MIN, SAMPLE_ZERO};
    run_items(directed_items, 0, 0, 1'b0);

    // unity pass-through, negative full scale clamps
    write_reg(CFG_NUM0, COEF_UNITY);
    end_writes();
    directed_items = {SAMPLE_MAX, SAMPLE_MIN, SAMPLE_ONE, SAMPLE_NEG_ONE, SAMPLE_ZERO};
    run_items(directed_items, 0, 0, 1'b0);

    // writes to unused indexes are dropped
    write_reg(CFG_IDX_UNUSED_LO, COEF_MAX);
    write_reg(CFG_IDX_UNUSED_HI, COEF_MIN);
    end_writes();
    directed_items = {SAMPLE_MAX};
    run_items(directed_items, 0, 0, 1'b0);

    // runaway feedback with zero limit, history saturates
    write_reg(CFG_NUM0, COEF_MAX);
    write_reg(CFG_NUM1, COEF_MIN);
    write_reg(CFG_NUM2, COEF_MIN);
    write_reg(CFG_NUM3, COEF_MIN);
    write_reg(CFG_DEN1, COEF_MIN);
    write_reg(CFG_DEN2, COEF_MIN);
    write_reg(CFG_DEN3, COEF_MIN);
    write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_ZERO));
    end_writes();
    directed_items = {SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN};
    run_items(directed_items, 0, 0, 1'b0);

    write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_MAX));
    end_writes();
    directed_items = {SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_ZERO};
    run_items(directed_items, 0, 0, 1'b0);

    write_reg(CFG_NUM1, COEF_MAX);
    write_reg(CFG_NUM2, COEF_MAX);
    write_reg(CFG_NUM3, COEF_MAX);
    write_reg(CFG_DEN1, COEF_MAX);
    write_reg(CFG_DEN2, COEF_MAX);
    write_reg(CFG_DEN3, COEF_MAX);
    write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_ONE));
    end_writes();
    directed_items = {SAMPLE_MIN, SAMPLE_MAX, SAMPLE_NEG_ONE};
    run_items(directed_items, 0, 0, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_config();
      run_random_phase(PHASE_ITEMS, src_modes[p % 4], snk_modes[p % 4], p == 4);
    end

    if (fail_count == 0 && filtered_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
